@@ hw/rtl/ase_pkg.sv @@
// shared constants, codes and control types of the array stack engine
package ase_pkg;

  // default number of stack entries
  localparam int DEPTH_DEF = 16;

  // fixed field widths
  localparam int FUNC_W   = 3;
  localparam int WORD_W   = 32;
  localparam int IDX_W    = 4;
  localparam int STATUS_W = 2;
  localparam int ENTRY_W  = 5;
  localparam int CAP_W    = 5;

  // configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_PUSH        = 3'd0;
  localparam logic [FUNC_W-1:0] FN_POP         = 3'd1;
  localparam logic [FUNC_W-1:0] FN_PEEK_INDEX  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_PEEK_TOP    = 3'd3;
  localparam logic [FUNC_W-1:0] FN_PEEK_BOTTOM = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_RANGE     = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic execute;
    logic load_out;
  } ase_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
  } ase_stat_t;

endpackage

@@ hw/rtl/ase_ram.sv @@
// generic single write, single read ram with registered read data
module ase_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/ase_ctrl.sv @@
// controller state machine of the array stack engine
module ase_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ase_pkg::ase_stat_t stat,
  output ase_pkg::ase_cmd_t  cmd
);
  import ase_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd.load_item = 1'b0;
    cmd.execute   = 1'b0;
    cmd.load_out  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.execute = 1'b1;
        state_nxt   = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  // an accepted word always goes on to execute
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == S_EXEC)
    else $error("accepted word did not move to execute");

  // execute always moves on to finish
  a_exec_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |=> state_r == S_FINISH)
    else $error("execute did not move to finish");

  // no result is loaded unless the output side can take it
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> stat.out_free)
    else $error("result loaded into busy output register");

endmodule

@@ hw/rtl/ase_datapath.sv @@
// datapath of the array stack engine: item registers, stack pointer, ram and result register
module ase_datapath #(
  parameter int DEPTH = ase_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ase_pkg::ase_cmd_t                   cmd,
  output ase_pkg::ase_stat_t                  stat,
  input  logic [ase_pkg::CAP_W-1:0]           cap_i,
  input  logic [ase_pkg::FUNC_W-1:0]          in_func,
  input  logic signed [ase_pkg::WORD_W-1:0]   in_push_value,
  input  logic [ase_pkg::IDX_W-1:0]           in_peek_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ase_pkg::WORD_W-1:0]   out_read_value,
  output logic [ase_pkg::STATUS_W-1:0]        out_status_code,
  output logic                                out_is_empty,
  output logic                                out_is_full,
  output logic [ase_pkg::ENTRY_W-1:0]         out_entry_count
);
  import ase_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int LW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int CW    = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  // captured item
  logic [FUNC_W-1:0]        func_r;
  logic signed [WORD_W-1:0] value_r;
  logic [IDX_W-1:0]         index_r;

  // stack state and execute results
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic [STATUS_W-1:0] status_r;
  logic [STATUS_W-1:0] status_nxt;
  logic                use_rd_r;
  logic                use_rd_nxt;

  // result register
  logic                     out_valid_r;
  logic signed [WORD_W-1:0] read_value_r;
  logic [STATUS_W-1:0]      status_out_r;
  logic                     empty_r;
  logic                     full_r;
  logic [ENTRY_W-1:0]       entry_count_r;

  // ram access
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic [LW-1:0] lim_eff;
  logic          is_empty;
  logic          is_full;

  // effective limit, clamped to 1..DEPTH
  always_comb begin
    if (cap_i == '0) begin
      lim_eff = LW'(1);
    end else if (LW'(cap_i) > LW'(DEPTH)) begin
      lim_eff = LW'(DEPTH);
    end else begin
      lim_eff = LW'(cap_i);
    end
  end

  assign is_empty = (count_r == '0);
  assign is_full  = (LW'(count_r) >= lim_eff);

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      func_r  <= in_func;
      value_r <= in_push_value;
      index_r <= in_peek_index;
    end
  end

  // operation decode
  always_comb begin
    count_nxt  = count_r;
    status_nxt = STAT_OK;
    use_rd_nxt = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = AW'(count_r);
    ram_raddr  = AW'(count_r - 1'b1);
    case (func_r)
      FN_PUSH: begin
        if (is_full) begin
          status_nxt = STAT_OVERFLOW;
        end else begin
          ram_we    = cmd.execute;
          count_nxt = count_r + 1'b1;
        end
      end
      FN_POP: begin
        if (is_empty) begin
          status_nxt = STAT_UNDERFLOW;
        end else begin
          use_rd_nxt = 1'b1;
          count_nxt  = count_r - 1'b1;
        end
      end
      FN_PEEK_INDEX: begin
        ram_raddr = AW'(index_r);
        if (CW'(index_r) >= CW'(count_r)) begin
          status_nxt = STAT_RANGE;
        end else begin
          use_rd_nxt = 1'b1;
        end
      end
      FN_PEEK_TOP: begin
        if (is_empty) begin
          status_nxt = STAT_UNDERFLOW;
        end else begin
          use_rd_nxt = 1'b1;
        end
      end
      FN_PEEK_BOTTOM: begin
        ram_raddr = '0;
        if (is_empty) begin
          status_nxt = STAT_UNDERFLOW;
        end else begin
          use_rd_nxt = 1'b1;
        end
      end
      default: begin
        status_nxt = STAT_OK;
      end
    endcase
  end

  // entry store
  ase_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (value_r),
    .re    (cmd.execute),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // stack pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.execute) begin
      count_r <= count_nxt;
    end
  end

  // execute outcome
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      status_r <= status_nxt;
      use_rd_r <= use_rd_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      read_value_r  <= use_rd_r ? ram_rdata : '0;
      status_out_r  <= status_r;
      empty_r       <= is_empty;
      full_r        <= is_full;
      entry_count_r <= ENTRY_W'(count_r);
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.out_free   = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_read_value  = read_value_r;
  assign out_status_code = status_out_r;
  assign out_is_empty    = empty_r;
  assign out_is_full     = full_r;
  assign out_entry_count = entry_count_r;

  // the pointer never passes the store depth
  a_count_depth: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(count_r) <= CW'(DEPTH))
    else $error("stack pointer beyond depth");

  // a successful push raises the pointer by one
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute && func_r == FN_PUSH && status_nxt == STAT_OK
    |=> count_r == $past(count_r) + 1'b1)
    else $error("push did not advance pointer");

  // a failed operation leaves the pointer alone
  a_fail_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute && status_nxt != STAT_OK |=> $stable(count_r))
    else $error("failed operation moved pointer");

endmodule

@@ hw/rtl/array_stack_engine.sv @@
// top level of the array stack engine: configuration register and unit wiring
// A LIFO stack of signed 32-bit words in a DEPTH-entry ram. Each accepted word
// carries one operation (push, pop, peek at index from the bottom, peek top,
// peek bottom) and yields exactly one result word with the data read, a status
// code, empty and full flags and the entry count after the operation. An
// operation goes through capture of the word at the accepting edge, then the
// single ram access and pointer update, then the load of the result register
// once the output can take it; the registered ram read gives the access a
// step of its own. The input stalls until the result is loaded, so a new word
// is taken only after the previous result has been loaded. capacity_limit
// sits at byte address 0 of the configuration port; zero acts as one and
// values above DEPTH act as DEPTH.
module array_stack_engine #(
  parameter int DEPTH = ase_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ase_pkg::ADDR_W-1:0]          paddr,
  input  logic [ase_pkg::DATA_W-1:0]          pwdata,
  output logic [ase_pkg::DATA_W-1:0]          prdata,
  output logic                                pready,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ase_pkg::FUNC_W-1:0]          in_func,
  input  logic signed [ase_pkg::WORD_W-1:0]   in_push_value,
  input  logic [ase_pkg::IDX_W-1:0]           in_peek_index,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ase_pkg::WORD_W-1:0]   out_read_value,
  output logic [ase_pkg::STATUS_W-1:0]        out_status_code,
  output logic                                out_is_empty,
  output logic                                out_is_full,
  output logic [ase_pkg::ENTRY_W-1:0]         out_entry_count
);
  import ase_pkg::*;

  logic [CAP_W-1:0] cap_r;
  logic             reg_sel;
  ase_cmd_t         cmd;
  ase_stat_t        stat;

  // register decode on the word index of the address
  assign reg_sel = (paddr[ADDR_W-1] == REG_CAPACITY);
  assign pready  = 1'b1;

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      cap_r <= pwdata[CAP_W-1:0];
    end
  end

  // read back
  assign prdata = reg_sel ? DATA_W'(cap_r) : '0;

  // controller
  ase_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  ase_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cap_i           (cap_r),
    .in_func         (in_func),
    .in_push_value   (in_push_value),
    .in_peek_index   (in_peek_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_value  (out_read_value),
    .out_status_code (out_status_code),
    .out_is_empty    (out_is_empty),
    .out_is_full     (out_is_full),
    .out_entry_count (out_entry_count)
  );

endmodule

@@ tb/sv/tb_top.sv @@
// self-checking testbench of the array stack engine: stimulus, scoreboard and run control
module tb_top;
  import ase_pkg::*;

  // byte address of the capacity register
  localparam logic [ADDR_W-1:0] CAP_ADDR = ADDR_W'(4 * REG_CAPACITY);
  // first of the undefined operation codes, which act as no operation
  localparam logic [FUNC_W-1:0] FN_UNDEF_LO = FN_PEEK_BOTTOM + 3'd1;
  // mismatch lines printed before the rest are only counted
  localparam int unsigned MAX_LINES = 100;

  // one result word as the block should present it
  typedef struct {
    logic signed [WORD_W-1:0] read_value;
    logic [STATUS_W-1:0]      status_code;
    logic                     is_empty;
    logic                     is_full;
    logic [ENTRY_W-1:0]       entry_count;
  } stack_result_t;

  // shadow stack and queue of expected result words
  class stack_scoreboard;
    logic [WORD_W-1:0] words [DEPTH_DEF];
    int unsigned       fill;
    logic [CAP_W-1:0]  cap_reg;
    stack_result_t     expected_q [$];
    int unsigned       errors;
    int unsigned       ops_noted;
    int unsigned       status_seen [4];

    function new();
      fill    = 0;
      cap_reg = CAP_RESET;
      errors  = 0;
      ops_noted = 0;
      foreach (status_seen[k]) status_seen[k] = 0;
    endfunction

    // zero acts as one, anything above the array size as the array size
    function int unsigned limit_in_use();
      if (cap_reg == 0) return 1;
      if (cap_reg > DEPTH_DEF) return DEPTH_DEF;
      return cap_reg;
    endfunction

    function void set_limit(logic [CAP_W-1:0] value);
      cap_reg = value;
    endfunction

    // apply one accepted operation word and queue its result
    function void note_op(logic [FUNC_W-1:0] f, logic [WORD_W-1:0] v,
                          logic [IDX_W-1:0] i);
      stack_result_t r;
      int unsigned   lim;
      lim           = limit_in_use();
      r.read_value  = '0;
      r.status_code = STAT_OK;
      case (f)
        FN_PUSH: begin
          if (fill >= lim) begin
            r.status_code = STAT_OVERFLOW;
          end else begin
            words[fill] = v;
            fill++;
          end
        end
        FN_POP: begin
          if (fill == 0) begin
            r.status_code = STAT_UNDERFLOW;
          end else begin
            fill--;
            r.read_value = words[fill];
          end
        end
        FN_PEEK_INDEX: begin
          if (i >= fill) r.status_code = STAT_RANGE;
          else r.read_value = words[i];
        end
        FN_PEEK_TOP: begin
          if (fill == 0) r.status_code = STAT_UNDERFLOW;
          else r.read_value = words[fill - 1];
        end
        FN_PEEK_BOTTOM: begin
          if (fill == 0) r.status_code = STAT_UNDERFLOW;
          else r.read_value = words[0];
        end
        default: begin
        end
      endcase
      r.is_empty    = (fill == 0);
      r.is_full     = (fill >= lim);
      r.entry_count = ENTRY_W'(fill);
      status_seen[r.status_code]++;
      ops_noted++;
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      if (errors < MAX_LINES) $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    // compare one result word with the oldest expectation
    task check_result(logic [WORD_W-1:0] rv, logic [STATUS_W-1:0] st, logic emp,
                      logic ful, logic [ENTRY_W-1:0] cnt);
      stack_result_t want;
      if (expected_q.size() == 0) begin
        report("result word with nothing expected");
        return;
      end
      want = expected_q.pop_front();
      if (rv !== want.read_value)
        report($sformatf("read_value %h, expected %h", rv, want.read_value));
      if (st !== want.status_code)
        report($sformatf("status_code %0d, expected %0d", st, want.status_code));
      if (emp !== want.is_empty)
        report($sformatf("is_empty %b, expected %b", emp, want.is_empty));
      if (ful !== want.is_full)
        report($sformatf("is_full %b, expected %b", ful, want.is_full));
      if (cnt !== want.entry_count)
        report($sformatf("entry_count %0d, expected %0d", cnt, want.entry_count));
    endtask
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [ADDR_W-1:0]         paddr;
  logic [DATA_W-1:0]         pwdata;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;
  logic                      in_valid;
  logic                      in_stall;
  logic [FUNC_W-1:0]         in_func;
  logic signed [WORD_W-1:0]  in_push_value;
  logic [IDX_W-1:0]          in_peek_index;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [WORD_W-1:0]  out_read_value;
  logic [STATUS_W-1:0]       out_status_code;
  logic                      out_is_empty;
  logic                      out_is_full;
  logic [ENTRY_W-1:0]        out_entry_count;

  stack_scoreboard sb = new();
  bit          calm_tail = 1'b0;
  int unsigned settings_written = 0;

  array_stack_engine #(.DEPTH(DEPTH_DEF)) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_push_value   (in_push_value),
    .in_peek_index   (in_peek_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_value  (out_read_value),
    .out_status_code (out_status_code),
    .out_is_empty    (out_is_empty),
    .out_is_full     (out_is_full),
    .out_entry_count (out_entry_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // overall time limit
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  // monitor: check results before noting a newly accepted word at the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_result(out_read_value, out_status_code, out_is_empty, out_is_full,
                        out_entry_count);
      if (in_valid && !in_stall)
        sb.note_op(in_func, in_push_value, in_peek_index);
    end
  end

  // result side back-pressure in random bursts
  initial begin
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (calm_tail) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 1'b0;
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8))
          @(posedge clk);
      end
    end
  end

  // offer one operation word, with an optional gap first, and wait for acceptance
  task send_op(logic [FUNC_W-1:0] f, logic [WORD_W-1:0] v, logic [IDX_W-1:0] i);
    if (!calm_tail && $urandom_range(0, 3) == 0) begin
      in_valid      <= 1'b0;
      in_func       <= FUNC_W'($urandom);
      in_push_value <= $urandom;
      in_peek_index <= IDX_W'($urandom);
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= f;
    in_push_value <= v;
    in_peek_index <= i;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // stop offering words and wait until every result word has come back
  task wait_drained();
    in_valid <= 1'b0;
    // let the monitor note the last accepted word first
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write the capacity register through the configuration port
  task write_capacity(logic [CAP_W-1:0] value);
    logic [DATA_W-1:0] word;
    word          = $urandom;
    word[CAP_W-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.set_limit(value);
    settings_written++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // pick a push value, leaning on the extremes now and then
  function automatic logic [WORD_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // random operations in segments that fill, drain or mix the stack
  task run_random(int unsigned n_items);
    int unsigned       mode;
    int unsigned       seg_left;
    int unsigned       r;
    int unsigned       push_th;
    int unsigned       pop_th;
    logic [FUNC_W-1:0] f;
    logic [IDX_W-1:0]  idx;
    seg_left = 0;
    mode     = 0;
    for (int unsigned k = 0; k < n_items; k++) begin
      if (seg_left == 0) begin
        mode     = $urandom_range(0, 2);
        seg_left = $urandom_range(6, 30);
      end
      seg_left--;
      push_th = (mode == 0) ? 60 : (mode == 1) ? 15 : 30;
      pop_th  = push_th + ((mode == 1) ? 50 : 20);
      r = $urandom_range(0, 99);
      if (r < push_th) f = FN_PUSH;
      else if (r < pop_th) f = FN_POP;
      else begin
        case ($urandom_range(0, 6))
          0, 1, 2: f = FN_PEEK_INDEX;
          3: f = FN_PEEK_TOP;
          4: f = FN_PEEK_BOTTOM;
          5: f = FN_UNDEF_LO + FUNC_W'($urandom_range(0, 2));
          default: f = FN_PEEK_INDEX;
        endcase
      end
      if ($urandom_range(0, 1) && sb.fill != 0) idx = IDX_W'($urandom_range(0, sb.fill - 1));
      else idx = IDX_W'($urandom_range(0, 15));
      send_op(f, pick_value(), idx);
    end
  endtask

  // main sequence
  initial begin
    logic [CAP_W-1:0] phase_caps [10];
    phase_caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd2, 5'd10, 5'd0, 5'd0, 5'd16};
    phase_caps[7] = CAP_W'($urandom_range(0, 31));
    phase_caps[8] = CAP_W'($urandom_range(1, 16));

    rst_n         <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    in_valid      <= 1'b0;
    in_func       <= FN_PUSH;
    in_push_value <= '0;
    in_peek_index <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty stack at the reset capacity: underflow, range and an undefined code
    send_op(FN_POP, 32'h0, 4'd0);
    send_op(FN_PEEK_TOP, 32'h0, 4'd0);
    send_op(FN_PEEK_BOTTOM, 32'h0, 4'd0);
    send_op(FN_PEEK_INDEX, 32'h0, 4'd0);
    send_op(FN_UNDEF_LO, 32'hffff_ffff, 4'd15);
    // extreme words, then peeks inside and outside the filled part
    send_op(FN_PUSH, 32'h7fff_ffff, 4'd0);
    send_op(FN_PUSH, 32'h8000_0000, 4'd15);
    send_op(FN_PUSH, 32'h0000_0000, 4'd0);
    send_op(FN_PUSH, 32'hffff_ffff, 4'd0);
    send_op(FN_PEEK_INDEX, 32'h0, 4'd0);
    send_op(FN_PEEK_INDEX, 32'h0, 4'd3);
    send_op(FN_PEEK_INDEX, 32'h0, 4'd4);
    send_op(FN_PEEK_INDEX, 32'h0, 4'd15);
    send_op(FN_PEEK_TOP, 32'h0, 4'd0);
    send_op(FN_PEEK_BOTTOM, 32'h0, 4'd0);
    send_op(FN_UNDEF_LO + 3'd2, 32'h1234_5678, 4'd7);
    // capacity lowered below the count: push overflows, pop still works
    wait_drained();
    write_capacity(5'd3);
    send_op(FN_PUSH, 32'h5555_aaaa, 4'd0);
    send_op(FN_POP, 32'h0, 4'd0);
    send_op(FN_PEEK_TOP, 32'h0, 4'd0);
    // zero capacity acts as one
    wait_drained();
    write_capacity(5'd0);
    send_op(FN_PUSH, 32'h0f0f_0f0f, 4'd0);
    send_op(FN_POP, 32'h0, 4'd0);
    // capacity above the array size acts as the array size
    wait_drained();
    write_capacity(5'd31);
    send_op(FN_PUSH, 32'hdead_beef, 4'd0);
    send_op(FN_UNDEF_LO + 3'd1, 32'h0, 4'd0);
    send_op(FN_POP, 32'h0, 4'd0);
    send_op(FN_POP, 32'h0, 4'd0);
    send_op(FN_POP, 32'h0, 4'd0);
    send_op(FN_POP, 32'h0, 4'd0);

    // random phases, each at its own capacity setting, with a calm tail at the end
    for (int p = 0; p < 10; p++) begin
      wait_drained();
      write_capacity(phase_caps[p]);
      if (p == 9) begin
        run_random(100);
        calm_tail = 1'b1;
        run_random(60);
      end else begin
        run_random(155);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    while (sb.expected_q.size() != 0) begin
      void'(sb.expected_q.pop_front());
      sb.report("expected result word never arrived");
    end

    $display("%0d operation words over %0d capacity settings, largest limit reached %0d",
             sb.ops_noted, settings_written + 1, DEPTH_DEF);
    $display("statuses: ok %0d, overflow %0d, underflow %0d, out of range %0d; errors %0d",
             sb.status_seen[STAT_OK], sb.status_seen[STAT_OVERFLOW],
             sb.status_seen[STAT_UNDERFLOW], sb.status_seen[STAT_RANGE], sb.errors);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
